[hdl/ps2q_pkg.sv]
// Package for the PS/2 set 1 scancode to key queue.
// Holds queue sizing, key codes, scancode constants, keymap tables and shared structs.
// No dependencies.
package ps2q_pkg;

  // Queue sizing: the ring holds QUEUE_DEPTH-1 keys
  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int KEY_W       = 9;

  // Beat modes on the input channel
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Scancode set 1 constants
  localparam logic [7:0] SC_PREFIX  = 8'hE0;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_UP      = 7'h48;
  localparam logic [6:0] SC_DOWN    = 7'h50;
  localparam logic [6:0] SC_LEFT    = 7'h4B;
  localparam logic [6:0] SC_RIGHT   = 7'h4D;
  localparam logic [6:0] SC_HOME    = 7'h47;
  localparam logic [6:0] SC_END     = 7'h4F;
  localparam logic [6:0] SC_DELETE  = 7'h53;

  // Extended key codes
  localparam logic [KEY_W-1:0] KC_UP     = 9'd256;
  localparam logic [KEY_W-1:0] KC_DOWN   = 9'd257;
  localparam logic [KEY_W-1:0] KC_LEFT   = 9'd258;
  localparam logic [KEY_W-1:0] KC_RIGHT  = 9'd259;
  localparam logic [KEY_W-1:0] KC_HOME   = 9'd260;
  localparam logic [KEY_W-1:0] KC_END    = 9'd261;
  localparam logic [KEY_W-1:0] KC_DELETE = 9'd262;

  // ASCII letter bounds
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_CASE = 8'h20;

  // Unshifted keymap, indexed by make code below 0x40
  localparam logic [7:0] PLAIN_TAB [0:63] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Shifted keymap
  localparam logic [7:0] SHIFT_TAB [0:63] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Translated key headed for the queue
  typedef struct packed {
    logic             push;
    logic [KEY_W-1:0] key;
  } ps2q_push_t;

  // Queue status for the beat just accepted
  typedef struct packed {
    logic drop;
    logic pop_ok;
    logic nonempty;
  } ps2q_qstat_t;

endpackage

[hdl/ps2q_intf.sv]
// Channel interfaces for the PS/2 key queue: input beats and result beats.
// Depends on ps2q_pkg for widths.
interface ps2q_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] scancode;

  modport source (output valid, output mode, output scancode, input ready);
  modport sink   (input valid, input mode, input scancode, output ready);
endinterface

interface ps2q_out_if;
  logic                     valid;
  logic                     ready;
  logic                     key_valid;
  logic [ps2q_pkg::KEY_W-1:0] key_code;
  logic                     queue_nonempty;
  logic                     dropped;

  modport source (output valid, output key_valid, output key_code,
                  output queue_nonempty, output dropped, input ready);
  modport sink   (input valid, input key_valid, input key_code,
                  input queue_nonempty, input dropped, output ready);
endinterface

[hdl/ps2q_xlate.sv]
// Scancode translator: prefix and modifier tracking plus keymap lookup.
// Depends on ps2q_pkg.
module ps2q_xlate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_vld,
  input  logic [7:0]           scancode,
  output ps2q_pkg::ps2q_push_t push_o
);
  import ps2q_pkg::*;

  logic shift_r, ctrl_r, caps_r, prefix_r;
  logic shift_nxt, ctrl_nxt, caps_nxt, prefix_nxt;
  logic       rel;
  logic [6:0] code;
  logic [7:0] ch_tab;
  logic [7:0] ch_case;
  logic [7:0] ch_fin;
  logic       ch_ok;
  logic [KEY_W-1:0] ext_key;
  logic       is_lower, is_upper, lower2, upper2;

  assign rel  = scancode[7];
  assign code = scancode[6:0];

  // keymap lookup, case fixups and ctrl mapping
  always_comb begin
    ch_tab   = shift_r ? SHIFT_TAB[code[5:0]] : PLAIN_TAB[code[5:0]];
    is_lower = (ch_tab >= CH_LO_A) && (ch_tab <= CH_LO_Z);
    is_upper = (ch_tab >= CH_UP_A) && (ch_tab <= CH_UP_Z);
    ch_case  = ch_tab;
    if (caps_r && is_lower) begin
      ch_case = ch_tab - CH_CASE;
    end else if (caps_r && shift_r && is_upper) begin
      ch_case = ch_tab + CH_CASE;
    end
    lower2 = (ch_case >= CH_LO_A) && (ch_case <= CH_LO_Z);
    upper2 = (ch_case >= CH_UP_A) && (ch_case <= CH_UP_Z);
    ch_fin = ch_case;
    ch_ok  = 1'b1;
    if (ctrl_r) begin
      if (lower2) begin
        ch_fin = ch_case - CH_LO_A + 8'd1;
      end else if (upper2) begin
        ch_fin = ch_case - CH_UP_A + 8'd1;
      end else begin
        ch_ok = 1'b0;
      end
    end
  end

  // extended key decode
  always_comb begin
    unique case (code)
      SC_UP:     ext_key = KC_UP;
      SC_DOWN:   ext_key = KC_DOWN;
      SC_LEFT:   ext_key = KC_LEFT;
      SC_RIGHT:  ext_key = KC_RIGHT;
      SC_HOME:   ext_key = KC_HOME;
      SC_END:    ext_key = KC_END;
      SC_DELETE: ext_key = KC_DELETE;
      default:   ext_key = '0;
    endcase
  end

  // byte decode: modifier updates and push request
  always_comb begin
    shift_nxt  = shift_r;
    ctrl_nxt   = ctrl_r;
    caps_nxt   = caps_r;
    prefix_nxt = prefix_r;
    push_o     = '0;
    if (byte_vld) begin
      priority if (scancode == SC_PREFIX) begin
        prefix_nxt = 1'b1;
      end else if (prefix_r) begin
        prefix_nxt = 1'b0;
        priority if (code == SC_CTRL) begin
          ctrl_nxt = !rel;
        end else if (!rel && (ext_key != '0)) begin
          push_o.push = 1'b1;
          push_o.key  = ext_key;
        end else begin
          push_o.push = 1'b0;
        end
      end else if ((code == SC_LSHIFT) || (code == SC_RSHIFT)) begin
        shift_nxt = !rel;
      end else if (code == SC_CTRL) begin
        ctrl_nxt = !rel;
      end else if (code == SC_CAPS) begin
        if (!rel) begin
          caps_nxt = !caps_r;
        end
      end else if (!rel && !code[6] && (ch_tab != 8'h00) && ch_ok) begin
        push_o.push = 1'b1;
        push_o.key  = {1'b0, ch_fin};
      end else begin
        push_o.push = 1'b0;
      end
    end
  end

  // modifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      ctrl_r   <= 1'b0;
      caps_r   <= 1'b0;
      prefix_r <= 1'b0;
    end else begin
      shift_r  <= shift_nxt;
      ctrl_r   <= ctrl_nxt;
      caps_r   <= caps_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

[hdl/ps2q_queue.sv]
// Key ring: one synchronous memory with write and read pointers.
// Depends on ps2q_pkg. Read data is registered, available in the cycle after the pop.
module ps2q_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ps2q_pkg::ps2q_push_t        push_i,
  input  logic                        pop_req,
  output ps2q_pkg::ps2q_qstat_t       stat_o,
  output logic [ps2q_pkg::KEY_W-1:0]  rd_data
);
  import ps2q_pkg::*;

  logic [KEY_W-1:0] mem [QUEUE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;
  logic [PTR_W-1:0] wptr_r, rptr_r, wptr_nxt, rptr_nxt;
  logic [PTR_W-1:0] wptr_adv, rptr_adv;
  logic             full, empty, do_push, do_pop;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wptr_adv = advance(wptr_r);
  assign rptr_adv = advance(rptr_r);
  assign full     = (wptr_adv == rptr_r);
  assign empty    = (wptr_r == rptr_r);
  assign do_push  = push_i.push && !full;
  assign do_pop   = pop_req && !empty;

  // pointer next state and status for this beat
  always_comb begin
    wptr_nxt        = do_push ? wptr_adv : wptr_r;
    rptr_nxt        = do_pop ? rptr_adv : rptr_r;
    stat_o.drop     = push_i.push && full;
    stat_o.pop_ok   = do_pop;
    stat_o.nonempty = (wptr_nxt != rptr_nxt);
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  // key memory: push and pop never hit the same entry in one cycle
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_i.key;
    end
    if (do_pop) begin
      rd_data_r <= mem[rptr_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/ps2_set1_scancode_to_key_queue.sv]
// PS/2 set 1 scancode to key queue, top level.
// Each beat passes through stage 1 (memory read), then the output register, to the result beat.
// Throughput: one beat per cycle while out_if.ready is high; a stalled output register holds off in_if.ready.
// Reset: synchronous active-low rst_n clears modifiers, prefix, pointers and pipeline valids;
// key memory contents are not cleared. Depends on ps2q_pkg, ps2q_intf, ps2q_xlate, ps2q_queue.
module ps2_set1_scancode_to_key_queue (
  input  logic       clk,
  input  logic       rst_n,
  ps2q_in_if.sink    in_if,
  ps2q_out_if.source out_if
);
  import ps2q_pkg::*;

  logic             accept;
  logic             s1_move;
  ps2q_push_t       push;
  ps2q_qstat_t      qstat;
  logic [KEY_W-1:0] rd_data;

  logic             s1_v_r;
  ps2q_qstat_t      s1_stat_r;
  logic             out_v_r;
  logic             out_kv_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_ne_r;
  logic             out_drop_r;

  // handshake: stage 1 advances into an empty or draining output register
  assign s1_move     = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !s1_v_r || s1_move;
  assign accept      = in_if.valid && in_if.ready;

  ps2q_xlate u_xlate (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (accept && (in_if.mode == MODE_BYTE)),
    .scancode (in_if.scancode),
    .push_o   (push)
  );

  ps2q_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .pop_req (accept && (in_if.mode == MODE_READ)),
    .stat_o  (qstat),
    .rd_data (rd_data)
  );

  // stage 1: wait for memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stat_r <= qstat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_kv_r   <= s1_stat_r.pop_ok;
      out_key_r  <= s1_stat_r.pop_ok ? rd_data : '0;
      out_ne_r   <= s1_stat_r.nonempty;
      out_drop_r <= s1_stat_r.drop;
    end
  end

  assign out_if.valid          = out_v_r;
  assign out_if.key_valid      = out_kv_r;
  assign out_if.key_code       = out_key_r;
  assign out_if.queue_nonempty = out_ne_r;
  assign out_if.dropped        = out_drop_r;

endmodule
